// File: hdl/mlt_pkg.sv
// Package for the MAC learning table: sizes, command codes, shared types.
// No dependencies.
`default_nettype none
package mlt_pkg;
  localparam int TABLE_ENTRIES = 64;
  localparam int PORT_COUNT    = 16;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = 7;
  localparam int AGE_W   = 10;
  localparam int ADDR_W  = 48;
  localparam int PORT_W  = 4;
  localparam logic [AGE_W-1:0] AGE_MAX     = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RST = AGE_W'(30);

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_LEARN  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_APPLY = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } job_t;
endpackage
`default_nettype wire

// File: hdl/mlt_if.sv
// Valid/ready channel interfaces for the MAC learning table.
// Depends on mlt_pkg.
`default_nettype none
interface mlt_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [mlt_pkg::ADDR_W-1:0] mac_address;
  logic [mlt_pkg::PORT_W-1:0] port;
  modport source (output valid, command, mac_address, port, input ready);
  modport sink (input valid, command, mac_address, port, output ready);
endinterface

interface mlt_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [mlt_pkg::PORT_W-1:0] found_port;
  logic                       table_full;
  logic [mlt_pkg::CNT_W-1:0]  removed_count;
  modport source (output valid, hit, found_port, table_full, removed_count, input ready);
  modport sink (input valid, hit, found_port, table_full, removed_count, output ready);
endinterface

interface mlt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mlt_pkg::AGE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hdl/mlt_front.sv
// Front end: accepts commands, classifies them, holds a two-entry job queue.
// Depends on mlt_pkg.
`default_nettype none
module mlt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_command,
  input  wire logic [mlt_pkg::ADDR_W-1:0] in_addr,
  input  wire logic [mlt_pkg::PORT_W-1:0] in_port,
  output logic               job_valid,
  input  wire logic          job_ready,
  output mlt_pkg::job_t      job
);
  mlt_pkg::job_t q [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    fill;
  mlt_pkg::job_t cls;
  logic          push, pop;

  // Learn with out-of-range port becomes a no-op command
  always_comb begin
    cls.cmd  = mlt_pkg::cmd_t'(in_command);
    cls.addr = in_addr;
    cls.port = in_port;
    if (in_command == mlt_pkg::CMD_LEARN &&
        32'(in_port) >= mlt_pkg::PORT_COUNT) cls.cmd = mlt_pkg::CMD_NONE;
  end

  assign in_ready  = (fill != 2'd2);
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// File: hdl/mlt_back.sv
// Back end: scans the table one entry a cycle and carries out a job.
// Depends on mlt_pkg.
`default_nettype none
module mlt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [mlt_pkg::AGE_W-1:0] timeout,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire mlt_pkg::job_t job,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               hit,
  output logic [mlt_pkg::PORT_W-1:0] found_port,
  output logic               table_full,
  output logic [mlt_pkg::CNT_W-1:0]  removed_count,
  output logic               busy
);
  localparam int IW = mlt_pkg::IDX_W;
  localparam int N  = mlt_pkg::TABLE_ENTRIES;

  // Entry store: valid bits in flops, payload in memories
  logic [N-1:0]                entry_valid;
  logic [mlt_pkg::ADDR_W-1:0]  mem_addr [N];
  logic [mlt_pkg::PORT_W-1:0]  mem_port [N];
  logic [mlt_pkg::AGE_W-1:0]   mem_age  [N];
  logic [mlt_pkg::ADDR_W-1:0]  rd_addr;
  logic [mlt_pkg::PORT_W-1:0]  rd_port;
  logic [mlt_pkg::AGE_W-1:0]   rd_age;

  mlt_pkg::state_t state, state_next;
  mlt_pkg::job_t   cur;
  logic [IW:0]     ridx;      // read index issued
  logic [IW-1:0]   pidx;      // index whose data is in rd_*
  logic            pvalid;
  logic            found, free_seen;
  logic [IW-1:0]   found_idx, free_idx;
  logic [mlt_pkg::PORT_W-1:0] found_p;
  logic [mlt_pkg::CNT_W-1:0]  removed;
  logic [mlt_pkg::AGE_W-1:0]  age_inc;
  logic            match;

  assign job_ready = (state == mlt_pkg::ST_IDLE);
  assign out_valid = (state == mlt_pkg::ST_OUT);
  assign busy      = (state != mlt_pkg::ST_IDLE);
  assign match     = pvalid && entry_valid[pidx] && rd_addr == cur.addr;
  assign age_inc   = (rd_age == mlt_pkg::AGE_MAX) ? rd_age : rd_age + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) state <= mlt_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mlt_pkg::ST_IDLE:  if (job_valid) state_next = mlt_pkg::ST_SCAN;
      mlt_pkg::ST_SCAN:  if (ridx[IW] && !pvalid) state_next = mlt_pkg::ST_APPLY;
      mlt_pkg::ST_APPLY: state_next = mlt_pkg::ST_OUT;
      mlt_pkg::ST_OUT:   if (out_ready) state_next = mlt_pkg::ST_IDLE;
      default:           state_next = mlt_pkg::ST_IDLE;
    endcase
  end

  // Registered memory reads, one entry per cycle
  always_ff @(posedge clk) begin
    rd_addr <= mem_addr[ridx[IW-1:0]];
    rd_port <= mem_port[ridx[IW-1:0]];
    rd_age  <= mem_age[ridx[IW-1:0]];
    pidx    <= ridx[IW-1:0];
  end

  // Scan bookkeeping and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      pvalid      <= 1'b0;
    end else begin
      unique case (state)
        mlt_pkg::ST_IDLE: begin
          cur       <= job;
          ridx      <= '0;
          pvalid    <= 1'b0;
          found     <= 1'b0;
          free_seen <= 1'b0;
          removed   <= '0;
          found_p   <= '0;
          found_idx <= '0;
          free_idx  <= '0;
        end
        mlt_pkg::ST_SCAN: begin
          if (!ridx[IW]) ridx <= ridx + 1'b1;
          pvalid <= !ridx[IW];
          if (pvalid) begin
            if (match && !found) begin
              found     <= 1'b1;
              found_idx <= pidx;
              found_p   <= rd_port;
            end
            if (!entry_valid[pidx] && !free_seen) begin
              free_seen <= 1'b1;
              free_idx  <= pidx;
            end
            if (cur.cmd == mlt_pkg::CMD_TICK && entry_valid[pidx]) begin
              mem_age[pidx] <= age_inc;
              if (age_inc > timeout) begin
                entry_valid[pidx] <= 1'b0;
                if (removed != mlt_pkg::COUNT_MAX) removed <= removed + 1'b1;
              end
            end
          end
        end
        mlt_pkg::ST_APPLY: begin
          if (cur.cmd == mlt_pkg::CMD_LOOKUP && found) mem_age[found_idx] <= '0;
          if (cur.cmd == mlt_pkg::CMD_LEARN) begin
            if (found) begin
              mem_port[found_idx] <= cur.port;
              mem_age[found_idx]  <= '0;
            end else if (free_seen) begin
              entry_valid[free_idx] <= 1'b1;
              mem_addr[free_idx]    <= cur.addr;
              mem_port[free_idx]    <= cur.port;
              mem_age[free_idx]     <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register, valid in ST_OUT
  always_ff @(posedge clk) begin
    if (state == mlt_pkg::ST_APPLY) begin
      hit           <= 1'b0;
      found_port    <= '0;
      table_full    <= 1'b0;
      removed_count <= '0;
      case (cur.cmd)
        mlt_pkg::CMD_LOOKUP: begin
          hit        <= found;
          found_port <= found ? found_p : '0;
        end
        mlt_pkg::CMD_LEARN: begin
          hit        <= found;
          found_port <= found ? cur.port : '0;
          table_full <= !found && !free_seen;
        end
        mlt_pkg::CMD_TICK: removed_count <= removed;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/mac_learning_table_with_aging.sv
// Top level of the MAC learning table with aging.
// Depends on mlt_pkg, mlt_if, mlt_front, mlt_back.
//
// Use: commands (lookup, learn, aging tick) enter on cmd_in; one result per
// command leaves on res_out. The aging timeout is written through cfg; the
// user must write it only while the block is idle, which the block itself
// does not enforce. cfg is always ready.
// Path: a command passes the front queue, a 64-entry scan at one registered
// memory read per cycle, an apply state and the output register.
// The back end takes a new command only after the result of the last one
// has transferred and it is back in idle.
// The front queue holds two commands, so input transfers continue while the
// back end works or its result waits.
// Reset: all entries invalid, timeout 30, queues empty.
// A stalled receiver holds the result; the back end waits, then the front
// queue fills and cmd_in ready drops.
`default_nettype none
module mac_learning_table_with_aging (
  input wire logic clk,
  input wire logic rst,
  mlt_in_if.sink   cmd_in,
  mlt_out_if.source res_out,
  mlt_cfg_if.sink  cfg
);
  logic [mlt_pkg::AGE_W-1:0] timeout;
  logic          job_valid, job_ready, busy;
  mlt_pkg::job_t job;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) timeout <= mlt_pkg::TIMEOUT_RST;
    else if (cfg.valid) timeout <= cfg.data;
  end

  mlt_front u_front (
    .clk, .rst,
    .in_valid(cmd_in.valid), .in_ready(cmd_in.ready),
    .in_command(cmd_in.command), .in_addr(cmd_in.mac_address),
    .in_port(cmd_in.port),
    .job_valid, .job_ready, .job
  );

  mlt_back u_back (
    .clk, .rst, .timeout,
    .job_valid, .job_ready, .job,
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .hit(res_out.hit), .found_port(res_out.found_port),
    .table_full(res_out.table_full), .removed_count(res_out.removed_count),
    .busy
  );

  // A result is only shown while the back end holds a job
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> busy) else $error("result without job");
  // No hit and full together
  a_hit_full: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> !(res_out.hit && res_out.table_full))
    else $error("hit and table_full both set");
  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.removed_count))
    else $error("result dropped under stall");
endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the MAC learning table with aging.
// Depends on mlt_pkg, mlt_if and mac_learning_table_with_aging.
`default_nettype none
module testbench;

  typedef struct {
    logic [1:0]                 cmd;
    logic [mlt_pkg::ADDR_W-1:0] addr;
    logic [mlt_pkg::PORT_W-1:0] port;
  } cmd_item_t;

  typedef struct {
    logic                       hit;
    logic [mlt_pkg::PORT_W-1:0] port;
    logic                       full;
    logic [mlt_pkg::CNT_W-1:0]  removed;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mlt_in_if  cmd_ch ();
  mlt_out_if res_ch ();
  mlt_cfg_if cfg_ch ();

  mac_learning_table_with_aging u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_ch.sink),
    .res_out (res_ch.source),
    .cfg     (cfg_ch.sink)
  );

  // Shadow copy of the table
  logic                       shadow_valid [mlt_pkg::TABLE_ENTRIES];
  logic [mlt_pkg::ADDR_W-1:0] shadow_addr  [mlt_pkg::TABLE_ENTRIES];
  logic [mlt_pkg::PORT_W-1:0] shadow_port  [mlt_pkg::TABLE_ENTRIES];
  logic [mlt_pkg::AGE_W-1:0]  shadow_age   [mlt_pkg::TABLE_ENTRIES];
  logic [mlt_pkg::AGE_W-1:0]  shadow_timeout;

  // Timeouts used by the random phases
  logic [mlt_pkg::AGE_W-1:0]  phase_timeout [6] =
    '{10'd1, 10'd30, 10'd4, 10'd1023, 10'd0, 10'd12};

  cmd_item_t   pending_cmds[$];
  lookup_res_t expected_results[$];
  int          fail_count = 0;
  int          hold_off   = 0;
  logic        sender_paused = 1'b0;
  logic        cmd_taken  = 1'b0;
  int          burst_left = 0;
  int          gap_left   = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one command to the shadow table and return its result
  function automatic lookup_res_t table_apply(cmd_item_t c);
    lookup_res_t r;
    int slot;
    int free_slot;
    slot = -1;
    free_slot = -1;
    r = '{1'b0, '0, 1'b0, '0};
    for (int i = mlt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_addr[i] == c.addr) slot = i;
      if (!shadow_valid[i]) free_slot = i;
    end
    case (c.cmd)
      mlt_pkg::CMD_LOOKUP: begin
        if (slot >= 0) begin
          shadow_age[slot] = '0;
          r.hit = 1'b1;
          r.port = shadow_port[slot];
        end
      end
      mlt_pkg::CMD_LEARN: begin
        if (int'(c.port) < mlt_pkg::PORT_COUNT) begin
          if (slot >= 0) begin
            shadow_port[slot] = c.port;
            shadow_age[slot] = '0;
            r.hit = 1'b1;
            r.port = c.port;
          end else if (free_slot >= 0) begin
            shadow_valid[free_slot] = 1'b1;
            shadow_addr[free_slot] = c.addr;
            shadow_port[free_slot] = c.port;
            shadow_age[free_slot] = '0;
          end else begin
            r.full = 1'b1;
          end
        end
      end
      mlt_pkg::CMD_TICK: begin
        for (int i = 0; i < mlt_pkg::TABLE_ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            if (shadow_age[i] != mlt_pkg::AGE_MAX) shadow_age[i]++;
            if (shadow_age[i] > shadow_timeout) begin
              shadow_valid[i] = 1'b0;
              if (r.removed != mlt_pkg::COUNT_MAX) r.removed++;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Command driver: bursts and gaps, falling edge
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (gap_left > 0) gap_left--;
      if (cmd_ch.valid && !cmd_taken) begin
        // hold the offered item until its transfer
      end else if (pending_cmds.size() == 0 || sender_paused) begin
        cmd_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        cmd_ch.valid <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 150);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= pending_cmds[0].cmd;
        cmd_ch.mac_address <= pending_cmds[0].addr;
        cmd_ch.port        <= pending_cmds[0].port;
      end
    end
  end

  // Command monitor: predict on each accepted transfer
  always @(posedge clk) begin
    cmd_item_t c;
    cmd_taken = !rst && cmd_ch.valid && cmd_ch.ready;
    if (cmd_taken) begin
      c.cmd = cmd_ch.command;
      c.addr = cmd_ch.mac_address;
      c.port = cmd_ch.port;
      expected_results.push_back(table_apply(c));
      void'(pending_cmds.pop_front());
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result monitor: field-by-field compare
  always @(posedge clk) begin
    lookup_res_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (res_ch.hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, res_ch.hit);
          fail_count++;
        end
        if (res_ch.found_port !== e.port) begin
          $error("found_port: expected %0d, got %0d", e.port, res_ch.found_port);
          fail_count++;
        end
        if (res_ch.table_full !== e.full) begin
          $error("table_full: expected %0d, got %0d", e.full, res_ch.table_full);
          fail_count++;
        end
        if (res_ch.removed_count !== e.removed) begin
          $error("removed_count: expected %0d, got %0d", e.removed, res_ch.removed_count);
          fail_count++;
        end
      end
    end
  end

  // Addresses drawn from a small pool so that lookups hit
  logic [mlt_pkg::ADDR_W-1:0] addr_pool [24];

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int k;
    k = $urandom_range(0, 99);
    c.cmd = k < 40 ? mlt_pkg::CMD_LOOKUP : k < 80 ? mlt_pkg::CMD_LEARN :
            k < 97 ? mlt_pkg::CMD_TICK : mlt_pkg::CMD_NONE;
    if ($urandom_range(0, 9) == 0) c.addr = mlt_pkg::ADDR_W'({$urandom, $urandom});
    else c.addr = addr_pool[$urandom_range(0, 23)];
    c.port = mlt_pkg::PORT_W'($urandom);
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_timeout(logic [mlt_pkg::AGE_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_timeout = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic void add_cmd(logic [1:0] cmd, logic [mlt_pkg::ADDR_W-1:0] a,
                                  logic [mlt_pkg::PORT_W-1:0] p);
    pending_cmds.push_back('{cmd, a, p});
  endfunction

  // Stimulus
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = mlt_pkg::CMD_LOOKUP;
    cmd_ch.mac_address = '0;
    cmd_ch.port = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    shadow_timeout = mlt_pkg::TIMEOUT_RST;
    for (int i = 0; i < mlt_pkg::TABLE_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_addr[i] = '0;
      shadow_port[i] = '0;
      shadow_age[i] = '0;
    end
    for (int i = 0; i < 24; i++) addr_pool[i] = mlt_pkg::ADDR_W'({$urandom, $urandom});
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every command, unused command, ageing
    add_cmd(mlt_pkg::CMD_LOOKUP, '0, '0);
    add_cmd(mlt_pkg::CMD_LEARN, '0, 4'hF);
    add_cmd(mlt_pkg::CMD_LEARN, '1, 4'h0);
    add_cmd(mlt_pkg::CMD_LOOKUP, '0, '0);
    add_cmd(mlt_pkg::CMD_LOOKUP, '1, 4'hF);
    add_cmd(mlt_pkg::CMD_LEARN, '1, 4'hA);
    add_cmd(mlt_pkg::CMD_LOOKUP, '1, '0);
    add_cmd(mlt_pkg::CMD_NONE, '1, 4'hF);
    add_cmd(mlt_pkg::CMD_TICK, '0, '0);
    add_cmd(mlt_pkg::CMD_LOOKUP, 48'h5555_5555_5555, 4'h5);
    drain();

    // Timeout zero: every valid entry removed on the next tick
    write_timeout('0);
    add_cmd(mlt_pkg::CMD_TICK, '0, '0);
    add_cmd(mlt_pkg::CMD_LOOKUP, '1, '0);
    drain();

    // Fill the table, overflow it, and stall the receiver meanwhile
    write_timeout(10'd1023);
    hold_off = 600;
    for (int i = 0; i < mlt_pkg::TABLE_ENTRIES + 2; i++)
      add_cmd(mlt_pkg::CMD_LEARN, mlt_pkg::ADDR_W'(i + 100), mlt_pkg::PORT_W'(i));
    add_cmd(mlt_pkg::CMD_LEARN, '1, 4'h3);
    drain();
    for (int i = 0; i < 3; i++) add_cmd(mlt_pkg::CMD_TICK, '0, '0);
    drain();
    write_timeout(10'd2);
    add_cmd(mlt_pkg::CMD_LOOKUP, mlt_pkg::ADDR_W'(100), '0);
    add_cmd(mlt_pkg::CMD_TICK, '0, '0);
    add_cmd(mlt_pkg::CMD_TICK, '0, '0);
    drain();

    // Random phases across several timeouts
    foreach (phase_timeout[p]) begin
      write_timeout(phase_timeout[p]);
      for (int i = 0; i < 180; i++) pending_cmds.push_back(random_cmd());
      if (p == 2) begin
        // sender pauses until every expected result has come
        while (pending_cmds.size() > 90) @(posedge clk);
        sender_paused = 1'b1;
        while (expected_results.size() != 0) @(posedge clk);
        sender_paused = 1'b0;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
